// ===== sv/lrfb_pkg.sv =====
// shared types, codes and constants of the led ring frame buffer
package lrfb_pkg;

   localparam int MAX_LEDS = 64;
   localparam int IDX_W    = $clog2(MAX_LEDS);
   localparam int COUNT_W  = 7;
   localparam int LEVEL_W  = 7;

   // function codes of an input beat
   localparam logic [1:0] FUNC_SET_INDEX  = 2'd0;
   localparam logic [1:0] FUNC_SET_SECOND = 2'd1;
   localparam logic [1:0] FUNC_REFRESH    = 2'd2;
   localparam logic [1:0] FUNC_BRIGHTNESS = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   // register indexes
   localparam logic [1:0] REG_RING_LEN    = 2'd0;
   localparam logic [1:0] REG_ORIENTATION = 2'd1;
   localparam logic [1:0] REG_REVERSED    = 2'd2;

   localparam logic [COUNT_W-1:0] RING_LEN_RESET   = 7'd60;
   localparam logic [COUNT_W-1:0] MAX_COUNT        = COUNT_W'(MAX_LEDS);
   localparam logic [9:0]         SECONDS_PER_TURN = 10'd60;
   localparam logic [LEVEL_W-1:0] FULL_LEVEL       = 7'd100;
   // floor(x / 100) == (x * 5243) >> 19 for every x below 25600
   localparam logic [12:0]        RECIP_100        = 13'd5243;
   localparam int                 RECIP_SHIFT      = 19;

   typedef struct packed {
      logic [1:0]         func;
      logic [IDX_W-1:0]   position;
      logic [31:0]        pixel_value;
      logic [LEVEL_W-1:0] level;
      logic               force_req;
   } req_item_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] pixel_index;
      logic [31:0]      pixel_out;
      logic             changed;
      logic             bad_index;
      logic             last;
   } rsp_item_type;

endpackage

// ===== sv/led_ring_frame_buffer_core.sv =====
// led ring frame buffer: pixel store with dirty marks, refresh walker and apb registers
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | req_data  (func, position, ...)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (kind, pixel_index, ...)
//  csr     | in/out    | psel/penable, pready | paddr, pwdata, prdata
//
// set by second first runs the serial modulo unit, then reads the store as set by index does.
// a refresh walks the store one entry per cycle while rsp is not stalled, through the single memory
// read port; a brightness change is a forced refresh, an unchanged one gives no result.
// reset clears control state at once; store entries never written read as zero by valid bits.
// a stalled rsp beat freezes the whole pixel pipeline; req is taken only when v1 and v2 are empty.
module led_ring_frame_buffer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lrfb_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lrfb_pkg::rsp_item_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import lrfb_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_MOD       = 3'd1;
   localparam logic [2:0] ST_SET_RD    = 3'd2;
   localparam logic [2:0] ST_REF_START = 3'd3;
   localparam logic [2:0] ST_SCAN      = 3'd4;
   localparam logic [2:0] ST_DRAIN     = 3'd5;

   // configuration
   logic [COUNT_W-1:0] ring_len_ff;
   logic [1:0]         orient_ff;
   logic               reversed_ff;
   logic [1:0]         reg_idx;
   logic               cfg_write;

   // control
   logic [2:0]         state_ff, state_in;
   logic [LEVEL_W-1:0] level_ff;
   logic [31:0]        color_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               bad_ff;
   logic               force_ff;
   logic [IDX_W-1:0]   scan_ff;
   logic [8:0]         div_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [3:0]         mod_cnt_ff;

   // store
   logic [31:0]        mem [0:MAX_LEDS-1];
   logic [MAX_LEDS-1:0] stored_ff;
   logic [MAX_LEDS-1:0] dirty_ff;
   logic [31:0]        rd_data_ff;
   logic               rd_vld_ff;

   // pipeline
   logic               v1_ff, v2_ff, rsp_valid_ff;
   logic [1:0]         kind1_ff, kind2_ff;
   logic [IDX_W-1:0]   idx1_ff, idx2_ff;
   logic               bad1_ff, bad2_ff, last1_ff, last2_ff, chg2_ff;
   logic [14:0]        prod_ff [0:3];
   rsp_item_type       rsp_ff;

   // combinational
   logic [COUNT_W-1:0] n_eff;
   logic [IDX_W-1:0]   n_m1;
   logic [IDX_W-1:0]   first_led;
   logic [8:0]         first_prod;
   logic [9:0]         rev_sum;
   logic [8:0]         fwd_div, rev_div;
   logic [COUNT_W-1:0] rem_shift, rem_step;
   logic [LEVEL_W-1:0] level_sat;
   logic               req_take;
   logic               adv;
   logic               any_dirty, later_dirty, scan_end, emit;
   logic               push, rd_en, clear_dirty;
   logic [1:0]         push_kind;
   logic [IDX_W-1:0]   push_idx;
   logic               push_bad, push_last;
   logic [31:0]        stored_word;
   logic               set_chg;
   logic               mem_we;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_len_ff  <= RING_LEN_RESET;
         orient_ff    <= '0;
         reversed_ff  <= 1'b0;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_RING_LEN:    ring_len_ff  <= pwdata[COUNT_W-1:0];
            REG_ORIENTATION: orient_ff    <= pwdata[1:0];
            REG_REVERSED:    reversed_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_RING_LEN:    prdata = {{(32-COUNT_W){1'b0}}, ring_len_ff};
         REG_ORIENTATION: prdata = {30'd0, orient_ff};
         REG_REVERSED:    prdata = {31'd0, reversed_ff};
         default:         prdata = '0;
      endcase
   end

   // ---------------- index mapping ----------------
   always_comb begin
      if (ring_len_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (ring_len_ff > MAX_COUNT) begin
         n_eff = MAX_COUNT;
      end else begin
         n_eff = ring_len_ff;
      end
   end

   assign n_m1       = IDX_W'(n_eff - COUNT_W'(1));
   assign first_prod = 9'(orient_ff) * 9'(n_eff);
   assign first_led  = IDX_W'(first_prod >> 2);
   assign fwd_div    = 9'(req_data.position) + 9'(first_led);
   // 60 + first - second, lifted by four ring lengths so it stays positive
   assign rev_sum    = SECONDS_PER_TURN + 10'(first_led) + 10'({n_eff, 2'b00})
                       - 10'(req_data.position);
   assign rev_div    = rev_sum[8:0];

   // one restoring remainder step per cycle
   assign rem_shift = {rem_ff[COUNT_W-2:0], div_ff[8]};
   assign rem_step  = (rem_shift >= n_eff) ? rem_shift - n_eff : rem_shift;

   assign level_sat = (req_data.level > FULL_LEVEL) ? FULL_LEVEL : req_data.level;

   // ---------------- refresh scan helpers ----------------
   always_comb begin
      any_dirty   = 1'b0;
      later_dirty = 1'b0;
      for (int k = 0; k < MAX_LEDS; k++) begin
         if (dirty_ff[k] && (COUNT_W'(k) < n_eff)) begin
            any_dirty = 1'b1;
            if (COUNT_W'(k) > COUNT_W'(scan_ff)) begin
               later_dirty = 1'b1;
            end
         end
      end
   end

   assign scan_end = (scan_ff == n_m1);
   assign emit     = force_ff || dirty_ff[scan_ff];

   // ---------------- sequencer ----------------
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      push        = 1'b0;
      rd_en       = 1'b0;
      clear_dirty = 1'b0;
      push_kind   = KIND_ACK;
      push_idx    = idx_ff;
      push_bad    = 1'b0;
      push_last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_data.func)
                  FUNC_SET_INDEX:  state_in = ST_SET_RD;
                  FUNC_SET_SECOND: state_in = ST_MOD;
                  FUNC_REFRESH:    state_in = ST_REF_START;
                  default: begin
                     if (level_sat != level_ff) begin
                        state_in = ST_REF_START;
                     end
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (mod_cnt_ff == '0) begin
               state_in = ST_SET_RD;
            end
         end
         ST_SET_RD: begin
            if (adv) begin
               push     = 1'b1;
               rd_en    = !bad_ff;
               push_bad = bad_ff;
               state_in = ST_DRAIN;
            end
         end
         ST_REF_START: begin
            if (force_ff || any_dirty) begin
               state_in = ST_SCAN;
            end else if (adv) begin
               push        = 1'b1;
               push_kind   = KIND_EMPTY;
               push_idx    = '0;
               clear_dirty = 1'b1;
               state_in    = ST_DRAIN;
            end
         end
         ST_SCAN: begin
            if (adv) begin
               push      = emit;
               rd_en     = emit;
               push_kind = KIND_PIXEL;
               push_idx  = scan_ff;
               push_last = force_ff ? scan_end : !later_dirty;
               if (scan_end) begin
                  clear_dirty = 1'b1;
                  state_in    = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_take && req_data.func == FUNC_BRIGHTNESS) begin
            level_ff <= level_sat;
         end
      end
   end

   // item payload, modulo unit and scan counter
   always_ff @(posedge clock) begin
      if (req_take) begin
         color_ff   <= req_data.pixel_value;
         force_ff   <= req_data.force_req || (req_data.func == FUNC_BRIGHTNESS);
         idx_ff     <= req_data.position;
         bad_ff     <= ({1'b0, req_data.position} >= n_eff);
         div_ff     <= reversed_ff ? rev_div : fwd_div;
         rem_ff     <= '0;
         mod_cnt_ff <= 4'd8;
         scan_ff    <= '0;
      end else if (state_ff == ST_MOD) begin
         div_ff     <= {div_ff[7:0], 1'b0};
         rem_ff     <= rem_step;
         mod_cnt_ff <= mod_cnt_ff - 4'd1;
         if (mod_cnt_ff == '0) begin
            idx_ff <= rem_step[IDX_W-1:0];
            bad_ff <= 1'b0;
         end
      end else if (state_ff == ST_SCAN && adv && !scan_end) begin
         scan_ff <= scan_ff + IDX_W'(1);
      end
   end

   // ---------------- store ----------------
   assign stored_word = rd_vld_ff ? rd_data_ff : 32'd0;
   assign set_chg     = (kind1_ff == KIND_ACK) && !bad1_ff && (stored_word != color_ff);
   assign mem_we      = adv && v1_ff && set_chg;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx1_ff] <= color_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[push_idx];
         rd_vld_ff  <= stored_ff[push_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         dirty_ff  <= '0;
      end else begin
         if (clear_dirty) begin
            dirty_ff <= '0;
         end
         if (mem_we) begin
            stored_ff[idx1_ff] <= 1'b1;
            dirty_ff[idx1_ff]  <= 1'b1;
         end
      end
   end

   // ---------------- result pipeline ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= push;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind1_ff <= push_kind;
         idx1_ff  <= push_idx;
         bad1_ff  <= push_bad;
         last1_ff <= push_last;

         kind2_ff <= kind1_ff;
         idx2_ff  <= idx1_ff;
         bad2_ff  <= bad1_ff;
         last2_ff <= last1_ff;
         chg2_ff  <= set_chg;
         for (int b = 0; b < 4; b++) begin
            if (kind1_ff == KIND_PIXEL) begin
               prod_ff[b] <= 15'(stored_word[8*b +: 8]) * 15'(level_ff);
            end else begin
               prod_ff[b] <= '0;
            end
         end

         rsp_ff.kind        <= kind2_ff;
         rsp_ff.pixel_index <= idx2_ff;
         rsp_ff.changed     <= chg2_ff;
         rsp_ff.bad_index   <= bad2_ff;
         rsp_ff.last        <= last2_ff;
         for (int b = 0; b < 4; b++) begin
            rsp_ff.pixel_out[8*b +: 8] <=
               8'((28'(prod_ff[b]) * 28'(RECIP_100)) >> RECIP_SHIFT);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- checks ----------------
   a_idle_means_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!v1_ff && !v2_ff))
      else $error("input taken while the pipeline still holds work");

   a_scan_clears_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && adv && scan_end) |=> (dirty_ff == '0))
      else $error("dirty marks survive the end of a refresh");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, idx1_ff} < n_eff))
      else $error("store written beyond the ring length");

endmodule
